// ----- rtl/biq_pkg.sv -----
// Shared types, constants and the microcode program of the biquad filter.
package biq_pkg;

  // Data widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;
  localparam int FRAC_BITS    = COEF_WIDTH - 2;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int PSUM_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH + 2;
  localparam int ACC_WIDTH    = PSUM_WIDTH + 2;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int PC_WIDTH     = 4;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [PSUM_WIDTH-1:0]   PSUM_MAX   = {1'b0, {(PSUM_WIDTH-1){1'b1}}};
  localparam logic signed [PSUM_WIDTH-1:0]   PSUM_MIN   = {1'b1, {(PSUM_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0]   COEF_ONE   = COEF_WIDTH'(1) << FRAC_BITS;

  // Register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_COEF_B0     = 3'd0,
    REG_COEF_B1     = 3'd1,
    REG_COEF_B2     = 3'd2,
    REG_COEF_A1     = 3'd3,
    REG_COEF_A2     = 3'd4,
    REG_FORM_SELECT = 3'd5
  } reg_idx_t;

  typedef enum logic {
    FORM_DF1  = 1'b0,
    FORM_TDF2 = 1'b1
  } form_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] b0;
    logic signed [COEF_WIDTH-1:0] b1;
    logic signed [COEF_WIDTH-1:0] b2;
    logic signed [COEF_WIDTH-1:0] a1;
    logic signed [COEF_WIDTH-1:0] a2;
    form_t                        form;
  } biq_cfg_t;

  // Control word fields
  typedef enum logic [2:0] {
    CS_B0, CS_B1, CS_B2, CS_A1, CS_A2
  } coef_sel_t;

  typedef enum logic [2:0] {
    OP_X, OP_X1, OP_X2, OP_Y1, OP_Y2, OP_Y
  } opnd_sel_t;

  typedef enum logic [2:0] {
    ACC_NOP, ACC_ZERO_ADD, ACC_ADD, ACC_SUB, ACC_PS1_ADD, ACC_PS2_ADD, ACC_PS2_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_ALWAYS, JMP_FORM
  } jmp_t;

  typedef struct packed {
    coef_sel_t             mul_coef;
    opnd_sel_t             mul_opnd;
    acc_op_t               acc_op;
    logic                  y_load;     // y_r <= rounded acc (transposed form)
    logic                  ps2_prod;   // ps2_r <= product (holds b2*x)
    logic                  ps1_sat;    // ps1_r <= saturated acc
    logic                  ps2_sat;    // ps2_r <= saturated acc
    logic                  ycalc;      // emit rounded acc directly
    logic                  shift_df1;  // advance direct form 1 delay line
    logic                  emit;       // load output register
    logic                  wait_in;    // wait for an input request
    jmp_t                  jmp;
    logic [PC_WIDTH-1:0]   target;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   go;   // current step executes this cycle
  } biq_ctrl_t;

  // Program entry points
  localparam logic [PC_WIDTH-1:0] PC_WAIT = 4'd0;
  localparam logic [PC_WIDTH-1:0] PC_DF1  = 4'd1;
  localparam logic [PC_WIDTH-1:0] PC_TDF2 = 4'd8;

  // Microcode program ROM
  function automatic ucode_t biq_ucode(input logic [PC_WIDTH-1:0] pc);
    ucode_t uc;
    uc = '0;
    uc.mul_coef = CS_B0;
    uc.mul_opnd = OP_X;
    uc.acc_op   = ACC_NOP;
    uc.jmp      = JMP_NEXT;
    uc.target   = PC_WAIT;
    case (pc)
      PC_WAIT: begin
        uc.wait_in = 1'b1;
        uc.jmp     = JMP_FORM;
        uc.target  = PC_TDF2;
      end
      // direct form 1: acc = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
      PC_DF1: begin
        uc.mul_coef = CS_B0; uc.mul_opnd = OP_X;
      end
      PC_DF1 + 4'd1: begin
        uc.mul_coef = CS_B1; uc.mul_opnd = OP_X1; uc.acc_op = ACC_ZERO_ADD;
      end
      PC_DF1 + 4'd2: begin
        uc.mul_coef = CS_B2; uc.mul_opnd = OP_X2; uc.acc_op = ACC_ADD;
      end
      PC_DF1 + 4'd3: begin
        uc.mul_coef = CS_A1; uc.mul_opnd = OP_Y1; uc.acc_op = ACC_ADD;
      end
      PC_DF1 + 4'd4: begin
        uc.mul_coef = CS_A2; uc.mul_opnd = OP_Y2; uc.acc_op = ACC_SUB;
      end
      PC_DF1 + 4'd5: begin
        uc.acc_op = ACC_SUB;
      end
      PC_DF1 + 4'd6: begin
        uc.ycalc = 1'b1; uc.shift_df1 = 1'b1; uc.emit = 1'b1;
        uc.jmp = JMP_ALWAYS; uc.target = PC_WAIT;
      end
      // transposed direct form 2
      PC_TDF2: begin
        uc.mul_coef = CS_B0; uc.mul_opnd = OP_X;
      end
      PC_TDF2 + 4'd1: begin
        uc.mul_coef = CS_B1; uc.mul_opnd = OP_X; uc.acc_op = ACC_PS1_ADD;
      end
      PC_TDF2 + 4'd2: begin
        uc.mul_coef = CS_B2; uc.mul_opnd = OP_X; uc.acc_op = ACC_PS2_ADD;
        uc.y_load = 1'b1;
      end
      PC_TDF2 + 4'd3: begin
        uc.mul_coef = CS_A1; uc.mul_opnd = OP_Y; uc.ps2_prod = 1'b1;
      end
      PC_TDF2 + 4'd4: begin
        uc.mul_coef = CS_A2; uc.mul_opnd = OP_Y; uc.acc_op = ACC_SUB;
      end
      PC_TDF2 + 4'd5: begin
        uc.ps1_sat = 1'b1; uc.acc_op = ACC_PS2_SUB;
      end
      PC_TDF2 + 4'd6: begin
        uc.ps2_sat = 1'b1; uc.emit = 1'b1;
        uc.jmp = JMP_ALWAYS; uc.target = PC_WAIT;
      end
      default: begin
        uc.jmp = JMP_ALWAYS; uc.target = PC_WAIT;
      end
    endcase
    return uc;
  endfunction

endpackage

// ----- rtl/biq_stream_if.sv -----
// Valid/ready stream interfaces for the sample input and result channels.
interface biq_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [biq_pkg::SAMPLE_WIDTH-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [biq_pkg::SAMPLE_WIDTH-1:0]  sample_out;
  logic                                     overflow;

  modport source (output valid, output sample_out, output overflow, input ready);
  modport sink   (input valid, input sample_out, input overflow, output ready);
endinterface

// ----- rtl/biq_cfg_regs.sv -----
// Coefficient and form select registers behind the write port.
module biq_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [biq_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [biq_pkg::COEF_WIDTH-1:0]      cfg_data,
  output biq_pkg::biq_cfg_t                   cfg
);
  import biq_pkg::*;

  biq_cfg_t cfg_r, cfg_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEF_B0:     cfg_nxt.b0 = cfg_data;
        REG_COEF_B1:     cfg_nxt.b1 = cfg_data;
        REG_COEF_B2:     cfg_nxt.b2 = cfg_data;
        REG_COEF_A1:     cfg_nxt.a1 = cfg_data;
        REG_COEF_A2:     cfg_nxt.a2 = cfg_data;
        REG_FORM_SELECT: cfg_nxt.form = form_t'(cfg_data[0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0   <= COEF_ONE;
      cfg_r.b1   <= '0;
      cfg_r.b2   <= '0;
      cfg_r.a1   <= '0;
      cfg_r.a2   <= '0;
      cfg_r.form <= FORM_DF1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/biq_sequencer.sv -----
// Step counter and program ROM that drive the biquad datapath.
module biq_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_busy,
  input  biq_pkg::form_t      form,
  output logic                in_ready,
  output biq_pkg::biq_ctrl_t  ctrl
);
  import biq_pkg::*;

  logic [PC_WIDTH-1:0] pc_r, pc_nxt;
  ucode_t              uc;
  logic                go;

  assign uc = biq_ucode(pc_r);

  // A step stalls while waiting for a request or for room in the output register
  assign go       = !(uc.wait_in && !in_valid) && !(uc.emit && out_busy);
  assign in_ready = uc.wait_in;

  // Next step address
  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      case (uc.jmp)
        JMP_NEXT:   pc_nxt = pc_r + 1'b1;
        JMP_ALWAYS: pc_nxt = uc.target;
        JMP_FORM:   pc_nxt = (form == FORM_TDF2) ? uc.target : pc_r + 1'b1;
        default:    pc_nxt = PC_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.uc = uc;
  assign ctrl.go = go;

  // Checks
  a_accept_leaves_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (pc_r != PC_WAIT))
    else $error("sequencer stayed in wait step after accepting a request");

  a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (go && uc.emit) |=> (pc_r == PC_WAIT))
    else $error("sequencer did not return to wait step after emitting");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(pc_r))
    else $error("step counter moved during a stall");

endmodule

// ----- rtl/biq_datapath.sv -----
// Shared multiplier, accumulator, filter state and output register.
module biq_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  biq_pkg::biq_ctrl_t                     ctrl,
  input  biq_pkg::biq_cfg_t                      cfg,
  input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [biq_pkg::SAMPLE_WIDTH-1:0] out_sample,
  output logic                                   out_overflow,
  output logic                                   out_busy
);
  import biq_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (FRAC_BITS - 1);

  ucode_t uc;
  logic   go;

  logic signed [SAMPLE_WIDTH-1:0] x_r, x1_r, x2_r, y1_r, y2_r, y_r;
  logic signed [SAMPLE_WIDTH-1:0] x_nxt, x1_nxt, x2_nxt, y1_nxt, y2_nxt, y_nxt;
  logic signed [PSUM_WIDTH-1:0]   ps1_r, ps2_r, ps1_nxt, ps2_nxt;
  logic signed [PROD_WIDTH-1:0]   prod_r, prod_nxt;
  logic signed [ACC_WIDTH-1:0]    acc_r, acc_nxt;
  logic                           ovf_r, ovf_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                           out_ovf_r, out_ovf_nxt;

  logic signed [COEF_WIDTH-1:0]   coef_op;
  logic signed [SAMPLE_WIDTH-1:0] opnd_op;
  logic signed [ACC_WIDTH-1:0]    prod_ext, ps1_ext, ps2_ext, base, rnd, yq;
  logic [ACC_WIDTH-SAMPLE_WIDTH:0] y_hi;
  logic [ACC_WIDTH-PSUM_WIDTH:0]   p_hi;
  logic                           y_ovf, p_ovf;
  logic signed [SAMPLE_WIDTH-1:0] y_sat, y_emit;
  logic signed [PSUM_WIDTH-1:0]   p_sat;
  logic                           ovf_emit;

  assign uc = ctrl.uc;
  assign go = ctrl.go;

  // Multiplier operand selection
  always_comb begin
    case (uc.mul_coef)
      CS_B0:   coef_op = cfg.b0;
      CS_B1:   coef_op = cfg.b1;
      CS_B2:   coef_op = cfg.b2;
      CS_A1:   coef_op = cfg.a1;
      CS_A2:   coef_op = cfg.a2;
      default: coef_op = '0;
    endcase
    case (uc.mul_opnd)
      OP_X:    opnd_op = x_r;
      OP_X1:   opnd_op = x1_r;
      OP_X2:   opnd_op = x2_r;
      OP_Y1:   opnd_op = y1_r;
      OP_Y2:   opnd_op = y2_r;
      OP_Y:    opnd_op = y_r;
      default: opnd_op = '0;
    endcase
  end

  assign prod_nxt = coef_op * opnd_op;

  // Sign extension to accumulator width
  assign prod_ext = {{(ACC_WIDTH-PROD_WIDTH){prod_r[PROD_WIDTH-1]}}, prod_r};
  assign ps1_ext  = {{(ACC_WIDTH-PSUM_WIDTH){ps1_r[PSUM_WIDTH-1]}}, ps1_r};
  assign ps2_ext  = {{(ACC_WIDTH-PSUM_WIDTH){ps2_r[PSUM_WIDTH-1]}}, ps2_r};

  // Accumulator
  always_comb begin
    case (uc.acc_op)
      ACC_ZERO_ADD, ACC_NOP: base = '0;
      ACC_ADD, ACC_SUB:      base = acc_r;
      ACC_PS1_ADD:           base = ps1_ext;
      ACC_PS2_ADD,
      ACC_PS2_SUB:           base = ps2_ext;
      default:               base = '0;
    endcase
    case (uc.acc_op)
      ACC_NOP:                  acc_nxt = acc_r;
      ACC_SUB, ACC_PS2_SUB:     acc_nxt = base - prod_ext;
      default:                  acc_nxt = base + prod_ext;
    endcase
  end

  // Round half up and saturate the accumulator to a sample
  assign rnd   = acc_r + ROUND_HALF;
  assign yq    = rnd >>> FRAC_BITS;
  assign y_hi  = yq[ACC_WIDTH-1:SAMPLE_WIDTH-1];
  assign y_ovf = !((&y_hi) || !(|y_hi));
  assign y_sat = y_ovf ? (yq[ACC_WIDTH-1] ? SAMPLE_MIN : SAMPLE_MAX) : yq[SAMPLE_WIDTH-1:0];

  // Saturate the accumulator to a partial sum
  assign p_hi  = acc_r[ACC_WIDTH-1:PSUM_WIDTH-1];
  assign p_ovf = !((&p_hi) || !(|p_hi));
  assign p_sat = p_ovf ? (acc_r[ACC_WIDTH-1] ? PSUM_MIN : PSUM_MAX) : acc_r[PSUM_WIDTH-1:0];

  assign y_emit   = uc.ycalc ? y_sat : y_r;
  assign ovf_emit = ovf_r || (uc.ycalc && y_ovf) || (uc.ps2_sat && p_ovf);

  // State and flag updates
  always_comb begin
    x_nxt   = x_r;
    x1_nxt  = x1_r;
    x2_nxt  = x2_r;
    y1_nxt  = y1_r;
    y2_nxt  = y2_r;
    y_nxt   = y_r;
    ps1_nxt = ps1_r;
    ps2_nxt = ps2_r;
    ovf_nxt = ovf_r;
    if (go) begin
      if (uc.wait_in) begin
        x_nxt   = in_sample;
        ovf_nxt = 1'b0;
      end
      if (uc.y_load) begin
        y_nxt   = y_sat;
        ovf_nxt = ovf_r || y_ovf;
      end
      if (uc.ps2_prod) begin
        ps2_nxt = {{(PSUM_WIDTH-PROD_WIDTH){prod_r[PROD_WIDTH-1]}}, prod_r};
      end
      if (uc.ps1_sat) begin
        ps1_nxt = p_sat;
        ovf_nxt = ovf_r || p_ovf;
      end
      if (uc.ps2_sat) begin
        ps2_nxt = p_sat;
      end
      if (uc.shift_df1) begin
        x2_nxt = x1_r;
        x1_nxt = x_r;
        y2_nxt = y1_r;
        y1_nxt = y_emit;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_ovf_nxt    = out_ovf_r;
    if (go && uc.emit) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = y_emit;
      out_ovf_nxt    = ovf_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      ps1_r       <= '0;
      ps2_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      y1_r        <= y1_nxt;
      y2_r        <= y2_nxt;
      ps1_r       <= ps1_nxt;
      ps2_r       <= ps2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    ovf_r        <= ovf_nxt;
    out_sample_r <= out_sample_nxt;
    out_ovf_r    <= out_ovf_nxt;
    if (go) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_overflow = out_ovf_r;
  assign out_busy     = out_valid_r && !out_ready;

endmodule

// ----- rtl/biquad_iir_filter_top.sv -----
// Biquad IIR section top level: config registers, microcode sequencer, datapath.
//
// in_chan carries signed samples (valid/ready); out_chan returns one filtered,
// rounded and saturated sample per input with an overflow flag. Coefficients
// b0, b1, b2, a1, a2 (signed Q2.16) and form_select (0 direct form 1,
// 1 transposed direct form 2) are written through cfg_wr_en/cfg_index/cfg_data
// while the block is idle; a write takes effect from the next sample.
// Each sample passes from the request to the result being loaded into the
// output register through one wait step plus seven program steps that share a
// single 18x16 multiplier and one accumulator. A new sample is taken only once
// the program is back at its wait step, as either form needs five products on
// that one multiplier. The output register lets the next request be accepted
// while a result waits; if the receiver stalls, the program holds at its emit
// step. Reset restores b0 = 1.0, the other coefficients to zero, direct form 1,
// and clears both forms' delay and partial-sum state; no clearing pass.
module biquad_iir_filter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  biq_in_if.sink                             in_chan,
  biq_out_if.source                          out_chan,
  input  logic                               cfg_wr_en,
  input  logic [biq_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [biq_pkg::COEF_WIDTH-1:0]     cfg_data
);
  import biq_pkg::*;

  biq_cfg_t  cfg;
  biq_ctrl_t ctrl;
  logic      out_busy;

  biq_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  biq_sequencer u_sequencer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .out_busy (out_busy),
    .form     (cfg.form),
    .in_ready (in_chan.ready),
    .ctrl     (ctrl)
  );

  biq_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .cfg          (cfg),
    .in_sample    (in_chan.sample_in),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_sample   (out_chan.sample_out),
    .out_overflow (out_chan.overflow),
    .out_busy     (out_busy)
  );

endmodule
